FILE: hw/rtl/mag_scd_pkg.sv
// shared types and constants for the magnetometer correct-and-denoise block
// no dependencies; imported by every module of the block

package mag_scd_pkg;

    // item widths on the stream ports
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 16;
    localparam int M_TDATA_W = 72;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Z      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_BAND   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_NARROW_BAND = 3'd7;

    // register reset values
    localparam logic signed [15:0] OFFSET_X_RST    = 16'sd133;
    localparam logic signed [15:0] OFFSET_Y_RST    = 16'sd122;
    localparam logic signed [15:0] OFFSET_Z_RST    = -16'sd162;
    localparam logic        [15:0] GAIN_RST        = 16'd2457;
    localparam logic        [19:0] WIDE_BAND_RST   = 20'd3072;
    localparam logic        [19:0] NARROW_BAND_RST = 20'd1536;

    // status bits
    localparam int STAT1_READY_BIT = 0;
    localparam int STAT2_OVF_BIT   = 3;

    // low-pass coefficient, Q0.16
    localparam logic [15:0] ALPHA_Q16 = 16'd3604;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // configuration registers as seen by the logic
    typedef struct packed {
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] offset_z;
        logic        [15:0] gain_x;
        logic        [15:0] gain_y;
        logic        [15:0] gain_z;
        logic        [19:0] wide_band;
        logic        [19:0] narrow_band;
    } t_cfg;

    // one queued item: offset-corrected raw counts
    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [16:0] dz;
    } t_q_entry;

    // queue status towards its neighbours
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: hw/rtl/mag_scd_front.sv
// front end: takes input items, drops unusable samples, removes the configured offsets
// depends on mag_scd_pkg; feeds mag_scd_fifo

module mag_scd_front import mag_scd_pkg::*; (
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // x_raw, y_raw, z_raw
    input  logic [S_TUSER_W-1:0] i_s_tuser,  // status_one, status_two
    input  t_cfg                 i_cfg,
    input  t_q_stat              i_q_stat,
    output logic                 o_push,
    output t_q_entry             o_entry
);

    logic signed [15:0] x_raw;
    logic signed [15:0] y_raw;
    logic signed [15:0] z_raw;
    logic [7:0]         status_one;
    logic [7:0]         status_two;
    logic               sample_ok;

    assign x_raw      = i_s_tdata[15:0];
    assign y_raw      = i_s_tdata[31:16];
    assign z_raw      = i_s_tdata[47:32];
    assign status_one = i_s_tuser[7:0];
    assign status_two = i_s_tuser[15:8];

    // an item is taken whenever the queue has room
    assign o_s_tready = !i_q_stat.full;

    // data ready set and no overflow
    assign sample_ok = status_one[STAT1_READY_BIT] && !status_two[STAT2_OVF_BIT];
    assign o_push    = i_s_tvalid && o_s_tready && sample_ok;

    // offset removal, one bit of growth
    always_comb begin
        o_entry.dx = {x_raw[15], x_raw} - {i_cfg.offset_x[15], i_cfg.offset_x};
        o_entry.dy = {y_raw[15], y_raw} - {i_cfg.offset_y[15], i_cfg.offset_y};
        o_entry.dz = {z_raw[15], z_raw} - {i_cfg.offset_z[15], i_cfg.offset_z};
    end

endmodule

FILE: hw/rtl/mag_scd_fifo.sv
// short register queue between the front and back ends
// depends on mag_scd_pkg for the entry and status types

module mag_scd_fifo import mag_scd_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    input  logic     i_pop,
    output t_q_entry o_head,
    output t_q_stat  o_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_q_entry         r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign o_stat.full  = (r_cnt == CNT_FULL);
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

FILE: hw/rtl/mag_scd_back.sv
// back end: gain correction and x/y step filter on one shared multiplier
// depends on mag_scd_pkg; reads from mag_scd_fifo, drives the result stream

module mag_scd_back import mag_scd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  t_q_stat              i_q_stat,
    input  t_q_entry             i_head,
    output logic                 o_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata   // x_field, y_field, z_field
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CX   = 8'b0000_0010,
        S_CY   = 8'b0000_0100,
        S_CZ   = 8'b0000_1000,
        S_FX   = 8'b0001_0000,
        S_FY   = 8'b0010_0000,
        S_FE   = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {
        CLS_WIDE   = 2'd0,
        CLS_NARROW = 2'd1,
        CLS_SMALL  = 2'd2
    } t_step_cls;

    localparam logic signed [40:0] SAT_MAX = 41'sd8388607;
    localparam logic signed [40:0] SAT_MIN = -41'sd8388608;

    // clamp to the signed 24-bit range
    function automatic logic signed [23:0] f_sat(input logic signed [40:0] v);
        logic signed [23:0] s_res;
        if (v > SAT_MAX) begin
            s_res = 24'sh7FFFFF;
        end else if (v < SAT_MIN) begin
            s_res = 24'sh800000;
        end else begin
            s_res = v[23:0];
        end
        return s_res;
    endfunction

    // Q.14 product to Q.8, round half up
    function automatic logic signed [23:0] f_corr(input logic signed [40:0] p);
        logic signed [40:0] s_t;
        s_t = (p + 41'sd32) >>> 6;
        return f_sat(s_t);
    endfunction

    // new filter memory for one axis
    function automatic logic signed [23:0] f_update(
        input t_step_cls          cls,
        input logic signed [23:0] last,
        input logic signed [23:0] v,
        input logic signed [40:0] prod
    );
        logic signed [24:0] s_sum;
        logic signed [40:0] s_rnd;
        logic signed [23:0] s_res;
        s_sum = {last[23], last} + {v[23], v};
        s_rnd = ((prod + 41'sd32768) >>> 16) + $signed({{17{last[23]}}, last});
        case (cls)
            CLS_WIDE:   s_res = v;
            CLS_NARROW: s_res = s_sum[24:1];
            CLS_SMALL:  s_res = f_sat(s_rnd);
            default:    s_res = v;
        endcase
        return s_res;
    endfunction

    t_state             r_state;
    t_state             n_state;
    t_q_entry           r_ent;
    logic signed [40:0] r_prod;
    logic signed [24:0] r_d;
    logic signed [23:0] r_x;
    logic signed [23:0] r_y;
    logic signed [23:0] r_z;
    logic signed [23:0] r_last_x;
    logic signed [23:0] r_last_y;
    logic               r_seeded;
    t_step_cls          r_cls;
    t_step_cls          n_cls;
    logic               r_ov;
    logic [M_TDATA_W-1:0] r_out;

    logic signed [24:0] mul_a;
    logic        [15:0] mul_b;
    logic signed [41:0] mul_p;
    logic        [24:0] d_mag;
    logic               out_load;

    // step class from the registered difference
    always_comb begin
        d_mag = r_d[24] ? 25'(-r_d) : 25'(r_d);
        if (d_mag > {5'b0, i_cfg.wide_band}) begin
            n_cls = CLS_WIDE;
        end else if (d_mag > {5'b0, i_cfg.narrow_band}) begin
            n_cls = CLS_NARROW;
        end else begin
            n_cls = CLS_SMALL;
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_CX: begin
                mul_a = 25'(r_ent.dx);
                mul_b = i_cfg.gain_x;
            end
            S_CY: begin
                mul_a = 25'(r_ent.dy);
                mul_b = i_cfg.gain_y;
            end
            S_CZ: begin
                mul_a = 25'(r_ent.dz);
                mul_b = i_cfg.gain_z;
            end
            S_FX, S_FY: begin
                mul_a = r_d;
                mul_b = ALPHA_Q16;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * $signed({1'b0, mul_b});
    end

    assign o_pop    = (r_state == S_IDLE) && !i_q_stat.empty;
    assign out_load = (r_state == S_OUT) && (!r_ov || i_m_tready);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (!i_q_stat.empty) n_state = S_CX;
            S_CX:    n_state = S_CY;
            S_CY:    n_state = S_CZ;
            S_CZ:    n_state = S_FX;
            S_FX:    n_state = r_seeded ? S_FY : S_OUT;
            S_FY:    n_state = S_FE;
            S_FE:    n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seeded <= 1'b0;
            r_last_x <= '0;
            r_last_y <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FX && !r_seeded) begin
                r_seeded <= 1'b1;
                r_last_x <= r_x;
                r_last_y <= r_y;
            end
            if (r_state == S_FY) begin
                r_last_x <= f_update(r_cls, r_last_x, r_x, r_prod);
            end
            if (r_state == S_FE) begin
                r_last_y <= f_update(r_cls, r_last_y, r_y, r_prod);
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[40:0];
        r_cls  <= n_cls;
        if (o_pop) begin
            r_ent <= i_head;
        end
        if (r_state == S_CY) begin
            r_x <= f_corr(r_prod);
        end
        if (r_state == S_CZ) begin
            r_y <= f_corr(r_prod);
            r_d <= {r_x[23], r_x} - {r_last_x[23], r_last_x};
        end
        if (r_state == S_FX) begin
            r_z <= f_corr(r_prod);
            r_d <= {r_y[23], r_y} - {r_last_y[23], r_last_y};
        end
        if (out_load) begin
            r_out <= {r_z, r_last_y, r_last_x};
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_out;

    // a result is only handed over once the filter has been seeded
    a_out_seeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> r_seeded)
        else $error("result stage reached without seeded filter");

    // the queue is only read when it holds an item
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_stat.empty)
        else $error("queue read while empty");

    // a new result only comes from the hand-off step
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_OUT))
        else $error("result valid raised outside hand-off");

    // filter steps only run after the seed
    a_filter_seeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FY || r_state == S_FE) |-> r_seeded)
        else $error("filter step before seed");

endmodule

FILE: hw/rtl/mag_sample_correct_and_denoise_top.sv
// top level of the magnetometer correct-and-denoise block: register file and wiring
// depends on mag_scd_pkg, mag_scd_front, mag_scd_fifo and mag_scd_back

// Each accepted item is checked at once: a sample without data ready or with the
// overflow bit set is dropped with no result, any other goes, offset-corrected,
// into a short queue, and the input side takes a new item every cycle while that
// queue has room. The back end then works through each queued sample in these steps
// (queue read, three gain multiplies, two filter multiplies, the y update, hand-off),
// all on one shared 25 x 16 multiplier, and reads the next queued sample only once
// it has handed off the last; the seeding sample skips the filter. Results sit in an
// output register; the next sample is worked on while a result waits, and the back
// end holds at hand-off until the waiting result is taken. Configuration writes are
// taken every cycle and should be made while idle.

module mag_sample_correct_and_denoise_top import mag_scd_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // x_raw, y_raw, z_raw
    input  logic [S_TUSER_W-1:0]  i_s_tuser,   // status_one, status_two
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // x_field, y_field, z_field
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    t_q_stat  q_stat;
    t_q_entry q_in;
    t_q_entry q_head;
    logic     q_push;
    logic     q_pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x    <= OFFSET_X_RST;
            r_cfg.offset_y    <= OFFSET_Y_RST;
            r_cfg.offset_z    <= OFFSET_Z_RST;
            r_cfg.gain_x      <= GAIN_RST;
            r_cfg.gain_y      <= GAIN_RST;
            r_cfg.gain_z      <= GAIN_RST;
            r_cfg.wide_band   <= WIDE_BAND_RST;
            r_cfg.narrow_band <= NARROW_BAND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OFFSET_X:    r_cfg.offset_x    <= i_cfg_data[15:0];
                CFG_OFFSET_Y:    r_cfg.offset_y    <= i_cfg_data[15:0];
                CFG_OFFSET_Z:    r_cfg.offset_z    <= i_cfg_data[15:0];
                CFG_GAIN_X:      r_cfg.gain_x      <= i_cfg_data[15:0];
                CFG_GAIN_Y:      r_cfg.gain_y      <= i_cfg_data[15:0];
                CFG_GAIN_Z:      r_cfg.gain_z      <= i_cfg_data[15:0];
                CFG_WIDE_BAND:   r_cfg.wide_band   <= i_cfg_data;
                CFG_NARROW_BAND: r_cfg.narrow_band <= i_cfg_data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    mag_scd_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cfg      (r_cfg),
        .i_q_stat   (q_stat),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    mag_scd_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    mag_scd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_stat   (q_stat),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
